FILE: design/swp_pkg.sv
// types and constants shared by the sorted window weighted pool unit
// no dependencies; imported by every module of the block
package swp_pkg;

   // fixed field widths
   localparam int RANK_W        = 4;
   localparam int VALUE_W       = 16;
   localparam int PROD_W        = 32;
   localparam int SUM_W         = 36;
   localparam int LEN_CFG_W     = 5;
   localparam int WEIGHT_DEPTH  = 16;
   localparam int WINDOW_LEN_RESET = 9;

   // request type codes
   localparam logic REQ_TYPE_WEIGHT  = 1'b0;
   localparam logic REQ_TYPE_ELEMENT = 1'b1;

   // input transaction payload
   typedef struct packed {
      logic                      req_type;
      logic [RANK_W-1:0]         weight_rank;
      logic signed [VALUE_W-1:0] weight_value;
      logic signed [VALUE_W-1:0] sample;
   } swp_req_type;

   // result transaction payload
   typedef struct packed {
      logic [RANK_W-1:0]       rank;
      logic [RANK_W-1:0]       source_position;
      logic signed [SUM_W-1:0] weighted_sum;
      logic                    last;
   } swp_rsp_type;

   // classified command kinds
   typedef enum logic {
      CMD_WEIGHT  = 1'b0,
      CMD_ELEMENT = 1'b1
   } swp_kind_type;

   // command passed from front to back through the queue
   typedef struct packed {
      swp_kind_type              kind;
      logic                      last;
      logic [RANK_W-1:0]         rank;
      logic signed [VALUE_W-1:0] data;
   } swp_cmd_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } swp_state_type;

endpackage

FILE: design/swp_front.sv
// front end: accepts transactions, holds window_len, tags the element that closes a window
// depends on swp_pkg
module swp_front import swp_pkg::*; #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swp_req_type           req_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_CFG_W-1:0]  csr_data,
   output logic                  cfg_clear,
   output logic                  q_wr_valid,
   output swp_cmd_type           q_wr_cmd,
   input  logic                  q_full
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [LEN_CFG_W-1:0] window_len_ff, window_len_in;
   logic [IDX_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     last_idx;
   logic                 req_fire;
   logic                 is_element;

   assign csr_ready  = 1'b1;
   assign cfg_clear  = csr_valid;
   assign req_ready  = !q_full;
   assign req_fire   = req_valid && req_ready;
   assign is_element = (req_payload.req_type == REQ_TYPE_ELEMENT);

   // effective window length minus one, with zero and oversize saturated
   always_comb begin
      if (window_len_ff == '0) begin
         last_idx = '0;
      end else if (32'(window_len_ff) > MAX_WINDOW) begin
         last_idx = IDX_W'(MAX_WINDOW - 1);
      end else begin
         last_idx = IDX_W'(window_len_ff - LEN_CFG_W'(1));
      end
   end

   // classify into a queue command
   always_comb begin
      q_wr_valid    = req_fire;
      q_wr_cmd.kind = is_element ? CMD_ELEMENT : CMD_WEIGHT;
      q_wr_cmd.last = is_element && (count_ff == last_idx);
      q_wr_cmd.rank = req_payload.weight_rank;
      q_wr_cmd.data = is_element ? req_payload.sample : req_payload.weight_value;
   end

   // window length register and element counter
   always_comb begin
      window_len_in = window_len_ff;
      count_in      = count_ff;
      if (csr_valid) begin
         window_len_in = csr_data;
         count_in      = '0;
      end else if (req_fire && is_element) begin
         count_in = (count_ff == last_idx) ? '0 : count_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= LEN_CFG_W'(WINDOW_LEN_RESET);
         count_ff      <= '0;
      end else begin
         window_len_ff <= window_len_in;
         count_ff      <= count_in;
      end
   end

endmodule

FILE: design/swp_queue.sv
// short command queue between front and back ends
// depends on swp_pkg
module swp_queue import swp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   input  swp_cmd_type wr_cmd,
   output logic        full,
   output logic        rd_valid,
   output swp_cmd_type rd_cmd,
   input  logic        rd_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   swp_cmd_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

FILE: design/swp_back.sv
// back end: insertion sorter row, rank sequencer, multiply stage and accumulating output register
// depends on swp_pkg
module swp_back import swp_pkg::*; #(
   parameter int MAX_WINDOW = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cfg_clear,
   input  logic        cmd_valid,
   input  swp_cmd_type cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output swp_rsp_type rsp_payload
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   typedef struct packed {
      logic                     first;
      logic                     last;
      logic [RANK_W-1:0]        rank;
      logic [RANK_W-1:0]        pos;
      logic signed [PROD_W-1:0] prod;
   } swp_prod_type;

   swp_state_type             state_ff, state_in;
   logic signed [VALUE_W-1:0] weight_ff [WEIGHT_DEPTH];
   logic signed [VALUE_W-1:0] weight_in [WEIGHT_DEPTH];
   logic signed [VALUE_W-1:0] val_ff [MAX_WINDOW];
   logic signed [VALUE_W-1:0] val_in [MAX_WINDOW];
   logic [RANK_W-1:0]         pos_ff [MAX_WINDOW];
   logic [RANK_W-1:0]         pos_in [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]     ge;
   logic [IDX_W-1:0]          cnt_ff, cnt_in;
   logic [IDX_W-1:0]          last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic                      p_valid_ff, p_valid_in;
   swp_prod_type              p_ff, p_in;
   logic                      out_valid_ff, out_valid_in;
   swp_rsp_type               out_ff, out_in;
   logic                      out_ok, p_adv, p_load_ok, emit_step, emit_last;
   logic                      do_insert, do_weight;
   logic signed [VALUE_W-1:0] w_sel;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // pipeline flow control
   assign out_ok    = !out_valid_ff || rsp_ready;
   assign p_adv     = p_valid_ff && out_ok;
   assign p_load_ok = !p_valid_ff || out_ok;
   assign emit_step = (state_ff == ST_EMIT) && p_load_ok;
   assign emit_last = (k_ff == last_idx_ff);

   // queue pop only while collecting
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign do_insert = cmd_pop && (cmd.kind == CMD_ELEMENT);
   assign do_weight = cmd_pop && (cmd.kind == CMD_WEIGHT);

   // cells that hold a value at least as large as the new one stay put
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         ge[i] = (IDX_W'(i) < cnt_ff) && (val_ff[i] >= cmd.data);
      end
   end

   // sorter row: insert on element, shift toward cell 0 while emitting
   always_comb begin
      int j;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         j         = 0;
         val_in[i] = val_ff[i];
         pos_in[i] = pos_ff[i];
         if (do_insert) begin
            j = (i == 0) ? 0 : i - 1;
            if (ge[i]) begin
               val_in[i] = val_ff[i];
            end else if (i == 0 || ge[j]) begin
               val_in[i] = cmd.data;
               pos_in[i] = RANK_W'(cnt_ff);
            end else if (IDX_W'(i) <= cnt_ff) begin
               val_in[i] = val_ff[j];
               pos_in[i] = pos_ff[j];
            end
         end else if (emit_step) begin
            j = (i == MAX_WINDOW - 1) ? i : i + 1;
            val_in[i] = val_ff[j];
            pos_in[i] = pos_ff[j];
         end
      end
   end

   // rank weight table
   always_comb begin
      for (int i = 0; i < WEIGHT_DEPTH; i++) begin
         weight_in[i] = weight_ff[i];
      end
      if (do_weight) begin
         weight_in[cmd.rank] = cmd.data;
      end
   end

   // ranks beyond the table use a zero weight
   always_comb begin
      if (32'(k_ff) < WEIGHT_DEPTH) begin
         w_sel = weight_ff[RANK_W'(k_ff)];
      end else begin
         w_sel = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      last_idx_in = last_idx_ff;
      k_in        = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cfg_clear) begin
               cnt_in = '0;
            end else if (do_insert) begin
               if (cmd.last) begin
                  last_idx_in = cnt_ff;
                  cnt_in      = '0;
                  k_in        = '0;
                  state_in    = ST_EMIT;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (emit_step) begin
               k_in = k_ff + IDX_W'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // multiply stage
   always_comb begin
      p_valid_in = p_valid_ff;
      p_in       = p_ff;
      if (emit_step) begin
         p_valid_in = 1'b1;
         p_in.first = (k_ff == '0);
         p_in.last  = emit_last;
         p_in.rank  = RANK_W'(k_ff);
         p_in.pos   = pos_ff[0];
         p_in.prod  = PROD_W'(w_sel) * PROD_W'(val_ff[0]);
      end else if (p_adv) begin
         p_valid_in = 1'b0;
      end
   end

   // accumulate into the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (p_adv) begin
         out_valid_in           = 1'b1;
         out_in.rank            = p_ff.rank;
         out_in.source_position = p_ff.pos;
         out_in.last            = p_ff.last;
         out_in.weighted_sum    = (p_ff.first ? '0 : out_ff.weighted_sum)
                                  + SUM_W'(p_ff.prod);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WEIGHT_DEPTH; i++) begin
            weight_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
         weight_ff    <= weight_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      last_idx_ff <= last_idx_in;
      p_ff        <= p_in;
      out_ff      <= out_in;
   end

   // no queue traffic while ranks are being emitted
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !cmd_pop)
      else $error("queue popped during emission");

   // the final rank returns the sequencer to collecting
   assert property (@(posedge clock) disable iff (reset)
      emit_step && emit_last |=> state_ff == ST_IDLE)
      else $error("sequencer stayed in emission after final rank");

   // running sums are built on the preceding rank
   assert property (@(posedge clock) disable iff (reset)
      p_adv && !p_ff.first |-> RANK_W'(out_ff.rank + RANK_W'(1)) == p_ff.rank)
      else $error("rank sequence broken in accumulator");

endmodule

FILE: design/sorted_window_weighted_pool_unit.sv
// path: closing element -> queue slot -> sorter row -> multiply stage -> output register
// throughput: one element per cycle into the sorter while idle with commands queued, then
// one rank per cycle unless rsp_ready stalls the output, for each element of the window
// weight writes update the rank weight table in the back end and produce no result
// reset: rank weights zero, window_len 9, any partial window discarded, queue emptied
module sorted_window_weighted_pool_unit import swp_pkg::*; #(
   parameter int MAX_WINDOW  = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  swp_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swp_rsp_type          rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LEN_CFG_W-1:0] csr_data
);

   logic        cfg_clear;
   logic        q_wr_valid, q_full, q_rd_valid, q_pop;
   swp_cmd_type q_wr_cmd, q_rd_cmd;

   // front end
   swp_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .cfg_clear   (cfg_clear),
      .q_wr_valid  (q_wr_valid),
      .q_wr_cmd    (q_wr_cmd),
      .q_full      (q_full)
   );

   // decoupling queue
   swp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_cmd   (q_wr_cmd),
      .full     (q_full),
      .rd_valid (q_rd_valid),
      .rd_cmd   (q_rd_cmd),
      .rd_pop   (q_pop)
   );

   // back end
   swp_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg_clear   (cfg_clear),
      .cmd_valid   (q_rd_valid),
      .cmd         (q_rd_cmd),
      .cmd_pop     (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
